[hdl/umdu_pkg.sv]
package umdu_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned FuncW    = 2;
    localparam int unsigned Steps    = 32;
    localparam int unsigned StepCntW = 5;
    localparam int unsigned InDataW  = 72;   // func + two operands, padded to whole bytes
    localparam int unsigned OutDataW = 32;

    localparam logic [StepCntW-1:0] LastStep = StepCntW'(Steps - 1);

    localparam logic [FuncW-1:0] FUNC_MUL = 2'd0;
    localparam logic [FuncW-1:0] FUNC_DIV = 2'd1;
    localparam logic [FuncW-1:0] FUNC_REM = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request and clear the working registers
        logic step;      // perform one multiply or divide iteration
        logic out_load;  // move the finished value into the output register
    } umdu_cmd_t;

endpackage

[hdl/umdu_ctrl.sv]
module umdu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output umdu_pkg::umdu_cmd_t cmd
);
    import umdu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [StepCntW-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LastStep)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/umdu_dp.sv]
module umdu_dp (
    input  logic                          clk,
    input  umdu_pkg::umdu_cmd_t           cmd,
    input  logic [umdu_pkg::FuncW-1:0]    func,
    input  logic [umdu_pkg::DataW-1:0]    operand_a,
    input  logic [umdu_pkg::DataW-1:0]    operand_b,
    output logic [umdu_pkg::DataW-1:0]    result
);
    import umdu_pkg::*;

    logic [FuncW-1:0] func_reg;
    logic [DataW-1:0] a_reg, a_next;      // multiplicand, or dividend bits still to shift in
    logic [DataW-1:0] b_reg, b_next;      // multiplier (shifts right) or divisor (held)
    logic [DataW-1:0] acc_reg, acc_next;  // product or quotient
    logic [DataW:0]   part_reg, part_next;
    logic [DataW-1:0] res_reg, res_value;
    logic             is_mul;
    logic [DataW:0]   part_shift;
    logic [DataW+1:0] diff;

    assign is_mul     = (func_reg == FUNC_MUL);
    assign part_shift = {part_reg[DataW-1:0], a_reg[DataW-1]};
    assign diff       = {1'b0, part_shift} - {2'b00, b_reg};

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        part_next = part_reg;
        if (cmd.load)
        begin
            a_next    = operand_a;
            b_next    = operand_b;
            acc_next  = '0;
            part_next = '0;
        end
        else if (cmd.step)
        begin
            a_next = {a_reg[DataW-2:0], 1'b0};
            if (is_mul)
            begin
                b_next = {1'b0, b_reg[DataW-1:1]};
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
            end
            else
            begin
                // Restoring step: keep the difference only when it did not borrow.
                if (!diff[DataW+1])
                begin
                    part_next = diff[DataW:0];
                    acc_next  = {acc_reg[DataW-2:0], 1'b1};
                end
                else
                begin
                    part_next = part_shift;
                    acc_next  = {acc_reg[DataW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        res_value = '0;
        unique case (func_reg)
            FUNC_MUL: res_value = acc_reg;
            FUNC_DIV: res_value = (b_reg == '0) ? '0 : acc_reg;
            FUNC_REM: res_value = (b_reg == '0) ? '0 : part_reg[DataW-1:0];
            default:  res_value = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
        end
        if (cmd.out_load)
        begin
            res_reg <= res_value;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        part_reg <= part_next;
    end

    assign result = res_reg;

endmodule

[hdl/unsigned_mul_div_unit_top.sv]
// Unsigned 32-bit multiply / divide / remainder unit.
// A request arrives on the slave stream (s_tvalid, s_tready, s_tdata) and carries
// an operation code and two unsigned operands. Code 0 returns the low 32 bits of
// the product, code 1 the quotient and code 2 the remainder of a restoring
// division; dividing by zero and the unused code 3 both return zero.
// The single result leaves on the master stream (m_tvalid, m_tready, m_tdata).
// From acceptance to m_tvalid, the operands are loaded at the accepting edge,
// 32 iterations of the shared radix-2 shift-add / shift-subtract datapath
// follow (one operand bit per cycle), and the output register is then written.
// The unit takes no new request until it is idle again: s_tready rises the
// cycle after the previous result enters the output register, so a new request
// can compute while the previous result still waits for the receiver.
// If the receiver stalls, the finished result holds in the output register and a
// following request waits after its last iteration until that register is free.
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// m_tvalid; no request in flight survives it.
module unsigned_mul_div_unit_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0 up: func[1:0], operand_a[33:2], operand_b[65:34], zero pad
    input  logic [umdu_pkg::InDataW-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0 up: result[31:0]
    output logic [umdu_pkg::OutDataW-1:0]     m_tdata
);
    import umdu_pkg::*;

    umdu_cmd_t        cmd;
    logic [FuncW-1:0] in_func;
    logic [DataW-1:0] in_a;
    logic [DataW-1:0] in_b;

    // Unpack the request fields; the top six bits are padding.
    assign in_func = s_tdata[FuncW-1:0];
    assign in_a    = s_tdata[FuncW+DataW-1:FuncW];
    assign in_b    = s_tdata[FuncW+2*DataW-1:FuncW+DataW];

    // The controller sequences load, the 32 iterations and the output write.
    umdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds operands, the accumulator or quotient, the partial
    // remainder, and the output register.
    umdu_dp u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .func      (in_func),
        .operand_a (in_a),
        .operand_b (in_b),
        .result    (m_tdata)
    );

endmodule

[tb/sv/unsigned_mul_div_unit_top_tb.sv]
module unsigned_mul_div_unit_top_tb;

    import umdu_pkg::*;

    // Code 3 selects no operation; the block answers it with zero.
    localparam logic [FuncW-1:0] FUNC_NONE = 2'd3;

    localparam int unsigned NumDirected   = 24;
    localparam int unsigned NumRandom     = 826;
    localparam int unsigned HoldOffCycles = 400;
    // Longest quiet stretch of a correct run is a receiver hold-off plus one
    // request latency and a long sender gap; this leaves several times that.
    localparam int unsigned StallLimit    = 3000;
    localparam int unsigned DrainCycles   = 40;

    // One request with the result it must produce.
    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] result;
    } mdu_op_t;

    // Directed row: when known is set, the result is typed in here and not
    // taken from the predictor.
    typedef struct {
        logic [FuncW-1:0] func;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        bit               known;
        logic [DataW-1:0] result;
    } directed_row_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OutDataW-1:0] m_tdata;

    mdu_op_t     pending_results[$];
    mdu_op_t     oldest;
    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned request_count  = 0;
    int unsigned func_count[4]  = '{0, 0, 0, 0};
    int unsigned zero_divisors  = 0;
    int unsigned hold_off_done  = 0;
    int unsigned quiet_cycles   = 0;
    bit          hold_off_req   = 1'b0;

    // Extremes of both operands, every operation, division by zero and the
    // unused operation code.
    directed_row_t directed_rows [NumDirected] = '{
        '{FUNC_MUL,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{FUNC_MUL,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_MUL,  32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_MUL,  32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0000},
        '{FUNC_MUL,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0000_0000},
        '{FUNC_DIV,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_REM,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_REM,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
        '{FUNC_REM,  32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
        '{FUNC_REM,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_REM,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
        '{FUNC_DIV,  32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0001},
        '{FUNC_REM,  32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
        '{FUNC_DIV,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_REM,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE},
        '{FUNC_DIV,  32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0000_0000},
        '{FUNC_REM,  32'h0000_0064, 32'h0000_0007, 1'b0, 32'h0000_0000},
        '{FUNC_NONE, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 32'h0000_0000},
        '{FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000}
    };

    unsigned_mul_div_unit_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Low product, quotient or remainder. Division by zero and the unused
    // code give zero.
    function automatic logic [DataW-1:0] predict_result(logic [FuncW-1:0] func,
                                                        logic [DataW-1:0] a,
                                                        logic [DataW-1:0] b);
        logic [2*DataW-1:0] product;
        product = {{DataW{1'b0}}, a} * {{DataW{1'b0}}, b};
        case (func)
            FUNC_MUL: return product[DataW-1:0];
            FUNC_DIV: return (b == '0) ? '0 : a / b;
            FUNC_REM: return (b == '0) ? '0 : a % b;
            default:  return '0;
        endcase
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 85)
            return $urandom_range(1, 3);
        if (k < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 100);
    endfunction

    // Operands lean toward the corners of the division: zero, all ones,
    // powers of two, small values and values with the top bit set.
    function automatic logic [DataW-1:0] random_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return $urandom_range(1, 255);
            4:       return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request, wait until it is taken, record what must come back,
    // then idle for the given number of cycles. The valid is only lowered when
    // a gap follows, so it never falls and rises at the same clock edge.
    task automatic send_request(mdu_op_t op, int unsigned gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW - FuncW - 2*DataW){1'b0}}, op.b, op.a, op.func};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(op);
        request_count++;
        func_count[op.func]++;
        if ((op.func == FUNC_DIV || op.func == FUNC_REM) && op.b == '0)
            zero_divisors++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender: directed table first, then random requests in blocks that
    // alternate between back-to-back offers and random gaps.
    initial
    begin : sender
        mdu_op_t     op;
        int unsigned k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumDirected; i++)
        begin
            op.func   = directed_rows[i].func;
            op.a      = directed_rows[i].a;
            op.b      = directed_rows[i].b;
            op.result = directed_rows[i].known ? directed_rows[i].result
                                               : predict_result(op.func, op.a, op.b);
            send_request(op, pick_gap());
        end

        for (int i = 0; i < NumRandom; i++)
        begin
            // Ask the receiver to hold off while offers keep coming, so the
            // unit fills up and has to stall its input.
            if (i == 0 || i == NumRandom / 2)
                hold_off_req = 1'b1;
            k = $urandom_range(0, 19);
            op.func = (k < 7)  ? FUNC_MUL :
                      (k < 13) ? FUNC_DIV :
                      (k < 19) ? FUNC_REM : FUNC_NONE;
            op.a      = random_operand();
            op.b      = random_operand();
            op.result = predict_result(op.func, op.a, op.b);
            send_request(op, ((i / 100) % 2 == 1) ? 0 : pick_gap());
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Ran %0d requests: %0d mul, %0d div, %0d rem, %0d unused code.",
                 request_count, func_count[FUNC_MUL], func_count[FUNC_DIV],
                 func_count[FUNC_REM], func_count[FUNC_NONE]);
        $display("Checked %0d results, %0d zero divisors, %0d hold-offs, %0d mismatches.",
                 checked_count, zero_divisors, hold_off_done, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: random ready patterns, with a long hold-off whenever the
    // sender asks for one.
    initial
    begin : receiver
        int unsigned run_len;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HoldOffCycles) @(posedge clk);
                hold_off_done++;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 3) != 0);
                run_len = pick_gap();
                repeat (run_len + 1) @(posedge clk);
            end
        end
    end

    // Every result taken by the receiver is compared with the oldest request
    // still waiting for its answer.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            checked_count <= checked_count + 1;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h arrived with no request waiting (expected none)",
                         $time, m_tdata);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (m_tdata !== oldest.result)
                begin
                    $display("%0t: func %0d a %h b %h: expected result %h, actual %h",
                             $time, oldest.func, oldest.a, oldest.b, oldest.result, m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: ends the run if neither side moves a request or a result
    // for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule
